// ----- rtl/hcw_pkg.sv -----
// hcw_pkg: shared widths, constants and helper functions of the color-wheel pixel block
// depends on nothing; every rtl file imports it
package hcw_pkg;

    localparam int MAX_DIM       = 4096;
    localparam int PERCENT_SCALE = 100;
    localparam int CHANNEL_MAX   = 255;

    // field and register widths
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int PCT_W   = 7;
    localparam int OFF_W   = 9;
    localparam int CH_W    = 8;

    // register indexes
    localparam logic [2:0] REG_FRAME_WIDTH     = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_HOLD_BRIGHTNESS = 3'd2;
    localparam logic [2:0] REG_SATURATION_PCT  = 3'd3;
    localparam logic [2:0] REG_BRIGHTNESS_PCT  = 3'd4;
    localparam logic [2:0] REG_HUE_OFFSET      = 3'd5;

    // geometry
    localparam int HALF_W  = $clog2(MAX_DIM / 2 + 1);
    localparam int SCALE_W = HALF_W;
    localparam int DELTA_W = ((COORD_W > HALF_W) ? COORD_W : HALF_W) + 1;
    localparam int D2_W    = 2 * (DELTA_W - 1) + 1;
    localparam int D2P_W   = D2_W + (D2_W % 2);

    // q1.16 ratios
    localparam int Q16_W   = 17;
    localparam int ONE_Q16 = 65536;

    // radius: digit-by-digit square root, then restoring divide
    localparam int SQ_STEPS  = D2P_W / 2 + 16;
    localparam int ROOT_W    = SQ_STEPS;
    localparam int REM_W     = ROOT_W + 2;
    localparam int DIV_STEPS = 16;

    // cordic angle in 2^-16 degree
    localparam int CORDIC_STEPS = 16;
    localparam int CX_W = DELTA_W + 19;
    localparam int Z_W  = 27;
    localparam int ARC_TABLE [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };
    localparam int HALF_TURN_Z = 180 * 65536;

    // hue in q9.8 degree
    localparam int H_W       = Z_W - 8 + 1;
    localparam int TURN_Q8   = 360 * 256;
    localparam int SECTOR_Q8 = 60 * 256;
    localparam int HUE_W     = 17;
    localparam int REMQ_W    = 14;
    // floor(n / 15) = (n * F_RECIP) >> F_SHIFT for n below 2^20
    localparam int F_SHIFT   = 24;
    localparam int F_RECIP   = (2 ** F_SHIFT + 14) / 15;
    localparam int F_RECIP_W = 21;
    localparam int FN_W      = REMQ_W + 6;

    // pipeline latencies, counted from the input register
    localparam int LAT_RADIUS = 1 + SQ_STEPS + DIV_STEPS;
    localparam int LAT_HUE    = 1 + CORDIC_STEPS + 3;
    localparam int HUE_DELAY  = LAT_RADIUS - LAT_HUE;

    // percent to q1.16 through a reciprocal
    localparam longint PCT_RECIP   = ((64'd1 << 32) + PERCENT_SCALE - 1) / PERCENT_SCALE;
    localparam int     PCT_RECIP_W = $clog2(PCT_RECIP + 1);
    localparam int     PCT_N_W     = PCT_W + 16;

    typedef struct packed {
        logic             hold;
        logic [Q16_W-1:0] s_fix;
        logic [Q16_W-1:0] v_fix;
    } hcw_hsv_cfg_t;

    function automatic logic [Q16_W-1:0] pct_to_q16(input logic [PCT_W-1:0] pct);
        logic [PCT_W-1:0]                 p;
        logic [PCT_N_W-1:0]               n;
        logic [PCT_N_W+PCT_RECIP_W-1:0]   prod;
        p    = (32'(pct) > PERCENT_SCALE) ? PCT_W'(PERCENT_SCALE) : pct;
        n    = {p, 16'b0};
        prod = (PCT_N_W + PCT_RECIP_W)'(n) * (PCT_N_W + PCT_RECIP_W)'(PCT_RECIP);
        return prod[32 +: Q16_W];
    endfunction

    function automatic logic [CH_W-1:0] to_channel(input logic [Q16_W-1:0] c);
        logic [Q16_W+CH_W-1:0] m;
        logic [CH_W:0]         r;
        m = {c, 8'b0} - (Q16_W + CH_W)'(c);
        r = m[Q16_W+CH_W-1:16];
        return (32'(r) > CHANNEL_MAX) ? CH_W'(CHANNEL_MAX) : r[CH_W-1:0];
    endfunction

endpackage

// ----- rtl/hcw_hue_unit.sv -----
// hcw_hue_unit: pipelined cordic angle, hue offset and wrap, sector split and fraction
// depends on hcw_pkg
module hcw_hue_unit import hcw_pkg::*; (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [DELTA_W-1:0] dx,
    input  logic signed [DELTA_W-1:0] dy,
    input  logic        [OFF_W-1:0]  hue_offset,
    output logic        [2:0]        sector,
    output logic        [15:0]       frac
);

    logic signed [CX_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [CX_W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg [0:CORDIC_STEPS];
    logic                   zero_reg [0:CORDIC_STEPS];

    logic signed [CX_W-1:0] x0, y0;
    assign x0 = CX_W'(dy) <<< 16;
    assign y0 = CX_W'(dx) <<< 16;

    // left half plane: rotate by half a turn first
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (dx == '0) && (dy == '0);
            if (dy < 0) begin
                x_reg[0] <= -x0;
                y_reg[0] <= -y0;
                z_reg[0] <= (dx >= 0) ? Z_W'(HALF_TURN_Z) : -Z_W'(HALF_TURN_Z);
            end else begin
                x_reg[0] <= x0;
                y_reg[0] <= y0;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + Z_W'(ARC_TABLE[i]);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - Z_W'(ARC_TABLE[i]);
                end
            end
        end
    end

    // round to q9.8, add offset, wrap into one turn
    logic signed [Z_W-1:0] z_round;
    logic signed [H_W-1:0] ang, off_q8, h_sum;
    logic [HUE_W-1:0]      hue_next, hue_reg;

    assign z_round = z_reg[CORDIC_STEPS] + Z_W'(128);
    assign ang     = zero_reg[CORDIC_STEPS] ? '0 : H_W'($signed(z_round[Z_W-1:8]));
    assign off_q8  = H_W'($signed(hue_offset)) <<< 8;
    assign h_sum   = ang + off_q8;

    always_comb begin
        if (h_sum < -TURN_Q8) begin
            hue_next = HUE_W'(h_sum + 2 * TURN_Q8);
        end else if (h_sum < 0) begin
            hue_next = HUE_W'(h_sum + TURN_Q8);
        end else if (h_sum < TURN_Q8) begin
            hue_next = HUE_W'(h_sum);
        end else begin
            hue_next = HUE_W'(h_sum - TURN_Q8);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg <= hue_next;
        end
    end

    // sector and remainder
    logic [2:0]       sec_next, sec1_reg, sec2_reg;
    logic [HUE_W-1:0] base;
    logic [REMQ_W-1:0] rem_reg;

    always_comb begin
        if (32'(hue_reg) >= 5 * SECTOR_Q8) begin
            sec_next = 3'd5;
        end else if (32'(hue_reg) >= 4 * SECTOR_Q8) begin
            sec_next = 3'd4;
        end else if (32'(hue_reg) >= 3 * SECTOR_Q8) begin
            sec_next = 3'd3;
        end else if (32'(hue_reg) >= 2 * SECTOR_Q8) begin
            sec_next = 3'd2;
        end else if (32'(hue_reg) >= SECTOR_Q8) begin
            sec_next = 3'd1;
        end else begin
            sec_next = 3'd0;
        end
        base = HUE_W'(32'(sec_next) * SECTOR_Q8);
    end

    logic [HUE_W-1:0] rem_full;
    assign rem_full = hue_reg - base;

    always_ff @(posedge aclk) begin
        if (en) begin
            sec1_reg <= sec_next;
            rem_reg  <= rem_full[REMQ_W-1:0];
        end
    end

    // frac = rem * 64 / 15 by reciprocal
    logic [FN_W+F_RECIP_W-1:0] fprod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sec2_reg  <= sec1_reg;
            fprod_reg <= (FN_W + F_RECIP_W)'({rem_reg, 6'b0})
                       * (FN_W + F_RECIP_W)'(F_RECIP);
        end
    end

    assign sector = sec2_reg;
    assign frac   = fprod_reg[F_SHIFT +: 16];

endmodule

// ----- rtl/hcw_radius_unit.sv -----
// hcw_radius_unit: squared distance, pipelined square root and divide by the scale
// depends on hcw_pkg
module hcw_radius_unit import hcw_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      valid_in,
    input  logic signed [DELTA_W-1:0] dx,
    input  logic signed [DELTA_W-1:0] dy,
    input  logic        [SCALE_W-1:0] scale,
    output logic                      valid_out,
    output logic        [Q16_W-1:0]   ratio
);

    logic [D2P_W-1:0]  d2_reg   [0:SQ_STEPS];
    logic [REM_W-1:0]  rem_reg  [0:SQ_STEPS];
    logic [ROOT_W-1:0] root_reg [0:SQ_STEPS];
    logic              sv_reg   [0:SQ_STEPS];

    logic signed [2*DELTA_W-1:0] sqx, sqy;
    assign sqx = dx * dx;
    assign sqy = dy * dy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sv_reg[0] <= 1'b0;
        end else if (en) begin
            sv_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d2_reg[0]   <= D2P_W'(unsigned'(sqx)) + D2P_W'(unsigned'(sqy));
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
        end
    end

    // square root of d2 * 2^32, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        logic [1:0]       pair;
        logic [REM_W-1:0] rem_sh, trial;
        if (2 * k + 1 < D2P_W) begin : g_data
            assign pair = d2_reg[k][D2P_W-1-2*k -: 2];
        end else begin : g_zero
            assign pair = 2'b00;
        end
        assign rem_sh = {rem_reg[k][REM_W-3:0], pair};
        assign trial  = {root_reg[k], 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sv_reg[k+1] <= 1'b0;
            end else if (en) begin
                sv_reg[k+1] <= sv_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                d2_reg[k+1] <= d2_reg[k];
                if (rem_sh >= trial) begin
                    rem_reg[k+1]  <= rem_sh - trial;
                    root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b1};
                end else begin
                    rem_reg[k+1]  <= rem_sh;
                    root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // restoring divide of the root by the scale, saturated at one
    logic [ROOT_W-1:0] dr_reg  [1:DIV_STEPS];
    logic [15:0]       q_reg   [1:DIV_STEPS];
    logic              sat_reg [1:DIV_STEPS];
    logic              dv_reg  [1:DIV_STEPS];

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [ROOT_W-1:0] dr_src, cmp;
        logic [15:0]       q_src;
        logic              sat_src, v_src;
        if (j == 0) begin : g_first
            assign dr_src  = root_reg[SQ_STEPS];
            assign q_src   = '0;
            assign sat_src = root_reg[SQ_STEPS] >= (ROOT_W'(scale) << 16);
            assign v_src   = sv_reg[SQ_STEPS];
        end else begin : g_next
            assign dr_src  = dr_reg[j];
            assign q_src   = q_reg[j];
            assign sat_src = sat_reg[j];
            assign v_src   = dv_reg[j];
        end
        assign cmp = ROOT_W'(scale) << (DIV_STEPS - 1 - j);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_reg[j+1] <= 1'b0;
            end else if (en) begin
                dv_reg[j+1] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sat_reg[j+1] <= sat_src;
                if (dr_src >= cmp) begin
                    dr_reg[j+1] <= dr_src - cmp;
                    q_reg[j+1]  <= {q_src[14:0], 1'b1};
                end else begin
                    dr_reg[j+1] <= dr_src;
                    q_reg[j+1]  <= {q_src[14:0], 1'b0};
                end
            end
        end
    end

    assign valid_out = dv_reg[DIV_STEPS];
    assign ratio     = sat_reg[DIV_STEPS] ? Q16_W'(ONE_Q16) : {1'b0, q_reg[DIV_STEPS]};

endmodule

// ----- rtl/hcw_hsv_unit.sv -----
// hcw_hsv_unit: two multiply stages of hsv to rgb, channel select and scaling
// depends on hcw_pkg
module hcw_hsv_unit import hcw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              valid_in,
    input  logic [2:0]        sector,
    input  logic [15:0]       frac,
    input  logic [Q16_W-1:0]  ratio,
    input  hcw_hsv_cfg_t      cfg,
    output logic              valid_out,
    output logic [CH_W-1:0]   red,
    output logic [CH_W-1:0]   green,
    output logic [CH_W-1:0]   blue
);

    logic [Q16_W-1:0] s, v, nf, ns;
    assign s  = cfg.hold ? ratio : cfg.s_fix;
    assign v  = cfg.hold ? cfg.v_fix : ratio;
    assign nf = Q16_W'(ONE_Q16) - Q16_W'(frac);
    assign ns = Q16_W'(ONE_Q16) - s;

    logic [2*Q16_W-1:0] sf_reg, snf_reg, pp_reg;
    logic [Q16_W-1:0]   v1_reg;
    logic [2:0]         sec1_reg;
    logic               val1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val1_reg <= 1'b0;
        end else if (en) begin
            val1_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sf_reg   <= (2*Q16_W)'(s) * (2*Q16_W)'(frac);
            snf_reg  <= (2*Q16_W)'(s) * (2*Q16_W)'(nf);
            pp_reg   <= (2*Q16_W)'(v) * (2*Q16_W)'(ns);
            v1_reg   <= v;
            sec1_reg <= sector;
        end
    end

    logic [Q16_W-1:0] aq, at;
    assign aq = Q16_W'(ONE_Q16) - sf_reg[16 +: Q16_W];
    assign at = Q16_W'(ONE_Q16) - snf_reg[16 +: Q16_W];

    logic [2*Q16_W-1:0] qp_reg, tp_reg;
    logic [Q16_W-1:0]   p2_reg, v2_reg;
    logic [2:0]         sec2_reg;
    logic               val2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            val2_reg <= 1'b0;
        end else if (en) begin
            val2_reg <= val1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qp_reg   <= (2*Q16_W)'(v1_reg) * (2*Q16_W)'(aq);
            tp_reg   <= (2*Q16_W)'(v1_reg) * (2*Q16_W)'(at);
            p2_reg   <= pp_reg[16 +: Q16_W];
            v2_reg   <= v1_reg;
            sec2_reg <= sec1_reg;
        end
    end

    logic [Q16_W-1:0] q, t, r, g, b;
    assign q = qp_reg[16 +: Q16_W];
    assign t = tp_reg[16 +: Q16_W];

    always_comb begin
        case (sec2_reg)
            3'd0: begin
                r = v2_reg; g = t;      b = p2_reg;
            end
            3'd1: begin
                r = q;      g = v2_reg; b = p2_reg;
            end
            3'd2: begin
                r = p2_reg; g = v2_reg; b = t;
            end
            3'd3: begin
                r = p2_reg; g = q;      b = v2_reg;
            end
            3'd4: begin
                r = t;      g = p2_reg; b = v2_reg;
            end
            default: begin
                r = v2_reg; g = p2_reg; b = q;
            end
        endcase
    end

    assign valid_out = val2_reg;
    assign red       = to_channel(r);
    assign green     = to_channel(g);
    assign blue      = to_channel(b);

endmodule

// ----- rtl/hsv_color_wheel_pixel.sv -----
// hsv_color_wheel_pixel: color-wheel test pattern pixel, one pixel per clock
// throughput: one beat per cycle; a stall freezes the pipe once a second result waits in the skid
// reset (aresetn, synchronous, active low) clears all valid bits and loads the register defaults
// depends on hcw_pkg, hcw_hue_unit, hcw_radius_unit, hcw_hsv_unit
module hsv_color_wheel_pixel import hcw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel coordinates in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_col[11:0], pixel_row[23:12]
    // rgb out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    // ---------------- configuration registers ----------------
    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic             hold_brightness_reg;
    logic [PCT_W-1:0] saturation_pct_reg, brightness_pct_reg;
    logic [OFF_W-1:0] hue_offset_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg     <= DIM_W'(640);
            frame_height_reg    <= DIM_W'(480);
            hold_brightness_reg <= 1'b0;
            saturation_pct_reg  <= PCT_W'(100);
            brightness_pct_reg  <= PCT_W'(100);
            hue_offset_reg      <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_WIDTH:     frame_width_reg     <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT:    frame_height_reg    <= pwdata[DIM_W-1:0];
                REG_HOLD_BRIGHTNESS: hold_brightness_reg <= pwdata[0];
                REG_SATURATION_PCT:  saturation_pct_reg  <= pwdata[PCT_W-1:0];
                REG_BRIGHTNESS_PCT:  brightness_pct_reg  <= pwdata[PCT_W-1:0];
                REG_HUE_OFFSET:      hue_offset_reg      <= pwdata[OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:     prdata = 32'(frame_width_reg);
            REG_FRAME_HEIGHT:    prdata = 32'(frame_height_reg);
            REG_HOLD_BRIGHTNESS: prdata = 32'(hold_brightness_reg);
            REG_SATURATION_PCT:  prdata = 32'(saturation_pct_reg);
            REG_BRIGHTNESS_PCT:  prdata = 32'(brightness_pct_reg);
            REG_HUE_OFFSET:      prdata = 32'(hue_offset_reg);
            default:             prdata = '0;
        endcase
    end

    // ---------------- derived geometry and levels ----------------
    // frame size clamps to the largest supported size, centre is half of it
    logic [DIM_W-1:0]   w_clamp, h_clamp;
    logic [HALF_W-1:0]  cx, cy, min_c;
    logic [SCALE_W-1:0] scale_reg;
    hcw_hsv_cfg_t       hsv_cfg_reg;

    assign w_clamp = (32'(frame_width_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_width_reg;
    assign h_clamp = (32'(frame_height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_height_reg;
    assign cx      = HALF_W'(w_clamp >> 1);
    assign cy      = HALF_W'(h_clamp >> 1);
    assign min_c   = (cx < cy) ? cx : cy;

    // the user must change these only while the pipe is empty (the block does not enforce it); the lag is harmless then
    always_ff @(posedge aclk) begin
        scale_reg         <= (min_c == '0) ? SCALE_W'(1) : min_c;
        hsv_cfg_reg.hold  <= hold_brightness_reg;
        hsv_cfg_reg.s_fix <= pct_to_q16(saturation_pct_reg);
        hsv_cfg_reg.v_fix <= pct_to_q16(brightness_pct_reg);
    end

    // ---------------- pipe enable and input register ----------------
    // the whole pipe moves together while the output skid is empty
    logic en;
    logic skid_valid_reg;
    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic                      v0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= DELTA_W'(s_tdata[11:0]) - DELTA_W'(cx);
            dy_reg <= DELTA_W'(s_tdata[23:12]) - DELTA_W'(cy);
        end
    end

    // ---------------- hue path ----------------
    logic [2:0]  hue_sector;
    logic [15:0] hue_frac;

    hcw_hue_unit u_hue (
        .aclk       (aclk),
        .en         (en),
        .dx         (dx_reg),
        .dy         (dy_reg),
        .hue_offset (hue_offset_reg),
        .sector     (hue_sector),
        .frac       (hue_frac)
    );

    // line the hue up with the longer radius path
    logic [2:0]  sec_dly_reg  [0:HUE_DELAY-1];
    logic [15:0] frac_dly_reg [0:HUE_DELAY-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sec_dly_reg[0]  <= hue_sector;
            frac_dly_reg[0] <= hue_frac;
            for (int i = 1; i < HUE_DELAY; i++) begin
                sec_dly_reg[i]  <= sec_dly_reg[i-1];
                frac_dly_reg[i] <= frac_dly_reg[i-1];
            end
        end
    end

    // ---------------- radius path ----------------
    logic             rad_valid;
    logic [Q16_W-1:0] rad_ratio;

    hcw_radius_unit u_radius (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (v0_reg),
        .dx        (dx_reg),
        .dy        (dy_reg),
        .scale     (scale_reg),
        .valid_out (rad_valid),
        .ratio     (rad_ratio)
    );

    // ---------------- hsv to rgb ----------------
    logic            pix_valid;
    logic [CH_W-1:0] pix_r, pix_g, pix_b;

    hcw_hsv_unit u_hsv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (rad_valid),
        .sector    (sec_dly_reg[HUE_DELAY-1]),
        .frac      (frac_dly_reg[HUE_DELAY-1]),
        .ratio     (rad_ratio),
        .cfg       (hsv_cfg_reg),
        .valid_out (pix_valid),
        .red       (pix_r),
        .green     (pix_g),
        .blue      (pix_b)
    );

    // ---------------- output register and skid ----------------
    // a beat leaving the pipe goes to the output register if it is free or being
    // taken, else it parks in the skid, which then holds the pipe
    logic [23:0] out_reg, skid_reg;
    logic        out_valid_reg;
    logic        take;
    assign take = out_valid_reg & m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (pix_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_reg <= skid_reg;
            end
        end else if (pix_valid) begin
            if (out_valid_reg && !m_tready) begin
                skid_reg <= {pix_b, pix_g, pix_r};
            end else begin
                out_reg <= {pix_b, pix_g, pix_r};
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule
